// ===== hdl/hts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

    localparam int MAX_DIM   = 256;
    localparam int FRAC_BITS = 8;

    localparam int QPOS_W   = 17;
    localparam int HEIGHT_W = 16;
    localparam int SAMPLE_W = 8;
    localparam int SCALE_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int CELL_W  = $clog2(MAX_DIM);
    localparam int DIM_W   = CELL_W + 1;
    localparam int CMP_W   = DIM_W + 1;
    localparam int ADDR_W  = 2 * CELL_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int FRAC_W  = FRAC_BITS;
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int ONE_FIX = 1 << FRAC_BITS;

    localparam int ACC_W       = SAMPLE_W + FRAC_BITS;
    localparam int NUM_W       = ACC_W + SCALE_W;
    localparam int QUO_IN_W    = NUM_W - FRAC_BITS;
    localparam int RECIP_SHIFT = QUO_IN_W + 8;
    localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + 64'd254) / 64'd255;
    localparam int RECIP_W     = RECIP_SHIFT - 7;
    localparam int HALF_DEN    = (255 * ONE_FIX) / 2;
    localparam int QUO_W       = NUM_W - RECIP_SHIFT + RECIP_W + QUO_IN_W - NUM_W + 1;

    localparam int MAC_A_W = QUO_IN_W;
    localparam int MAC_B_W = RECIP_W;
    localparam int MAC_W   = MAC_A_W + MAC_B_W;
    localparam int ADD_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               en;
        logic               load;
        logic [ADD_W-1:0]   addend;
        logic [MAC_A_W-1:0] a;
        logic [MAC_B_W-1:0] b;
    } mac_op_t;

endpackage

`default_nettype wire

// ===== hdl/heightfield_triangle_sampler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// cfg       in         cfg_we              cfg_index, cfg_data
// s         in         s_valid / s_ready   s_opcode, s_sample_index, s_sample_value,
//                                          s_query_x, s_query_z
// m         out        m_valid / m_ready   m_height_out, m_in_range
//
// A write beat produces no result. In a query, one multiply-add unit forms the cell
// address, three reads of the single heightmap port feed it the corners, and it then
// scales and divides by reciprocal multiplication. A query outside the grid skips to
// its done state. Reset restores the config registers, state and m_valid; heightmap
// contents are undefined until written. A result held by m_ready stalls the next query.

module heightfield_triangle_sampler_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [hts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [hts_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_opcode,
    input  wire logic [15:0]                         s_sample_index,
    input  wire logic [hts_pkg::SAMPLE_W-1:0]        s_sample_value,
    input  wire logic signed [hts_pkg::QPOS_W-1:0]   s_query_x,
    input  wire logic signed [hts_pkg::QPOS_W-1:0]   s_query_z,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [hts_pkg::HEIGHT_W-1:0]        m_height_out,
    output logic                                     m_in_range
);

    import hts_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BASE  = 4'd1;
    localparam logic [3:0] ST_RD0   = 4'd2;
    localparam logic [3:0] ST_RD1   = 4'd3;
    localparam logic [3:0] ST_RD2   = 4'd4;
    localparam logic [3:0] ST_ACC   = 4'd5;
    localparam logic [3:0] ST_SCALE = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam int SAT_W = MAC_W - RECIP_SHIFT;

    logic [3:0]          state_reg, state_next;
    logic [DIM_W-1:0]    cols_reg, rows_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [CELL_W-1:0]   cx_reg, cz_reg;
    logic [FRAC_W-1:0]   u_reg, v_reg;
    logic                tri_reg;
    logic                range_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic                m_valid_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                in_range_reg;

    logic [DIM_W-1:0]    cols_eff, rows_eff;
    logic [CELL_W-1:0]   cx_in, cz_in;
    logic                cell_ok;
    logic                accept;
    logic                ram_we;
    logic [ADDR_W-1:0]   raddr;
    logic [SAMPLE_W-1:0] rdata;
    logic [MAC_W-1:0]    acc;
    mac_op_t             mac_op;
    logic [WGT_W-1:0]    w_c, w_a, w_b;
    logic [SAT_W-1:0]    quo;
    logic [HEIGHT_W-1:0] height_sat;
    logic                out_free;

    assign cols_eff = (cols_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_reg;
    assign rows_eff = (rows_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_reg;

    assign cx_in = s_query_x[FRAC_BITS +: CELL_W];
    assign cz_in = s_query_z[FRAC_BITS +: CELL_W];
    assign cell_ok = !s_query_x[QPOS_W-1] && !s_query_z[QPOS_W-1]
                     && (CMP_W'(cx_in) + CMP_W'(2) <= CMP_W'(cols_eff))
                     && (CMP_W'(cz_in) + CMP_W'(2) <= CMP_W'(rows_eff));

    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;
    assign ram_we = accept && (s_opcode == OP_WRITE);
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg  <= DIM_W'(256);
            rows_reg  <= DIM_W'(256);
            scale_reg <= SCALE_W'(256);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRID_COLUMNS: cols_reg  <= cfg_data[DIM_W-1:0];
                REG_GRID_ROWS:    rows_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cx_reg    <= cx_in;
            cz_reg    <= cz_in;
            u_reg     <= s_query_x[FRAC_W-1:0];
            v_reg     <= s_query_z[FRAC_W-1:0];
            tri_reg   <= s_query_x[FRAC_W-1:0] > s_query_z[FRAC_W-1:0];
            range_reg <= cell_ok;
        end
        if (state_reg == ST_RD0) begin
            base_reg <= acc[ADDR_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_opcode == OP_QUERY)) begin
                    state_next = cell_ok ? ST_BASE : ST_DONE;
                end
            end
            ST_BASE:  state_next = ST_RD0;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_RD2;
            ST_RD2:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign w_c = tri_reg ? (WGT_W'(ONE_FIX) - WGT_W'(u_reg))
                         : (WGT_W'(ONE_FIX) - WGT_W'(v_reg));
    assign w_a = tri_reg ? WGT_W'(u_reg - v_reg) : WGT_W'(v_reg - u_reg);
    assign w_b = tri_reg ? WGT_W'(v_reg) : WGT_W'(u_reg);

    always_comb begin
        raddr = acc[ADDR_W-1:0];
        case (state_reg)
            ST_RD1:  raddr = tri_reg ? ADDR_W'(base_reg + ADDR_W'(1))
                                     : ADDR_W'(base_reg + ADDR_W'(cols_eff));
            ST_RD2:  raddr = ADDR_W'(base_reg + ADDR_W'(cols_eff) + ADDR_W'(1));
            default: raddr = acc[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        mac_op.en     = 1'b0;
        mac_op.load   = 1'b0;
        mac_op.addend = '0;
        mac_op.a      = '0;
        mac_op.b      = '0;
        case (state_reg)
            ST_BASE: begin
                mac_op.en     = 1'b1;
                mac_op.load   = 1'b1;
                mac_op.addend = ADD_W'(cx_reg);
                mac_op.a      = MAC_A_W'(cz_reg);
                mac_op.b      = MAC_B_W'(cols_eff);
            end
            ST_RD1: begin
                mac_op.en   = 1'b1;
                mac_op.load = 1'b1;
                mac_op.a    = MAC_A_W'(rdata);
                mac_op.b    = MAC_B_W'(w_c);
            end
            ST_RD2: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(rdata);
                mac_op.b  = MAC_B_W'(w_a);
            end
            ST_ACC: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(rdata);
                mac_op.b  = MAC_B_W'(w_b);
            end
            ST_SCALE: begin
                mac_op.en     = 1'b1;
                mac_op.load   = 1'b1;
                mac_op.addend = ADD_W'(HALF_DEN);
                mac_op.a      = MAC_A_W'(acc[ACC_W-1:0]);
                mac_op.b      = MAC_B_W'(scale_reg);
            end
            ST_DIV: begin
                mac_op.en   = 1'b1;
                mac_op.load = 1'b1;
                mac_op.a    = acc[NUM_W-1:FRAC_BITS];
                mac_op.b    = MAC_B_W'(RECIP);
            end
            default: begin
            end
        endcase
    end

    hts_mac u_mac (
        .aclk (aclk),
        .op   (mac_op),
        .acc  (acc)
    );

    hts_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_sample_index[ADDR_W-1:0]),
        .wdata (s_sample_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign quo = acc[MAC_W-1:RECIP_SHIFT];
    assign height_sat = (quo > SAT_W'({HEIGHT_W{1'b1}})) ? {HEIGHT_W{1'b1}}
                                                         : quo[HEIGHT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            height_reg   <= range_reg ? height_sat : '0;
            in_range_reg <= range_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_height_out = height_reg;
    assign m_in_range   = in_range_reg;

endmodule

`default_nettype wire

// ===== hdl/hts_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/hts_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hts_mac (
    input  wire logic                     aclk,
    input  wire hts_pkg::mac_op_t         op,
    output logic      [hts_pkg::MAC_W-1:0] acc
);

    import hts_pkg::*;

    logic [MAC_W-1:0] acc_reg;
    logic [MAC_W-1:0] acc_next;
    logic [MAC_W-1:0] prod;
    logic [MAC_W-1:0] base;

    assign prod = MAC_W'(op.a) * MAC_W'(op.b);
    assign base = op.load ? MAC_W'(op.addend) : acc_reg;
    assign acc_next = base + prod;

    always_ff @(posedge aclk) begin
        if (op.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import hts_pkg::*;

    typedef struct {
        logic [HEIGHT_W-1:0] height;
        logic                in_range;
    } height_result_t;

    class height_scoreboard;
        bit [SAMPLE_W-1:0] heights [DEPTH];
        bit                written [DEPTH];
        int unsigned       columns = 256;
        int unsigned       rows = 256;
        int unsigned       scale = 256;
        height_result_t    expected_heights [$];
        int                errors = 0;

        function int unsigned usable(int unsigned dim);
            return (dim > MAX_DIM) ? MAX_DIM : dim;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                REG_GRID_COLUMNS: columns = data[DIM_W-1:0];
                REG_GRID_ROWS: rows = data[DIM_W-1:0];
                REG_HEIGHT_SCALE: scale = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // The unscaled height is a*ONE + (b-a)*weight_b + (c-a)*weight_c over the chosen triangle.
        function bit locate_corners(input logic signed [QPOS_W-1:0] qx, qz,
                                    output int unsigned corner_a, corner_b, corner_c,
                                    output int weight_b, weight_c);
            int sx, sz, cols, rws, cx, cz, u, v, lower, upper;
            sx = qx;
            sz = qz;
            cols = usable(columns);
            rws = usable(rows);
            corner_a = 0;
            corner_b = 0;
            corner_c = 0;
            weight_b = 0;
            weight_c = 0;
            if (sx < 0 || sz < 0 || cols < 2 || rws < 2) return 0;
            cx = sx >> FRAC_BITS;
            cz = sz >> FRAC_BITS;
            if (cx + 2 > cols || cz + 2 > rws) return 0;
            u = sx & (ONE_FIX - 1);
            v = sz & (ONE_FIX - 1);
            lower = cx + cz * cols;
            upper = lower + cols;
            corner_b = upper + 1;
            corner_c = lower;
            if (u > v) begin
                corner_a = lower + 1;
                weight_b = v;
                weight_c = ONE_FIX - u;
            end else begin
                corner_a = upper;
                weight_b = u;
                weight_c = ONE_FIX - v;
            end
            return 1;
        endfunction

        function bit readable(logic signed [QPOS_W-1:0] qx, qz);
            int unsigned ia, ib, ic;
            int wb, wc;
            if (!locate_corners(qx, qz, ia, ib, ic, wb, wc)) return 1;
            return written[ia] && written[ib] && written[ic];
        endfunction

        function void note_beat(logic op, logic [15:0] index, logic [SAMPLE_W-1:0] value,
                                logic signed [QPOS_W-1:0] qx, qz);
            height_result_t r;
            int unsigned ia, ib, ic;
            int wb, wc;
            longint corner_a, corner_b, corner_c, acc, h;
            if (op == OP_WRITE) begin
                heights[index] = value;
                written[index] = 1'b1;
                return;
            end
            r.height = '0;
            r.in_range = 1'b0;
            if (locate_corners(qx, qz, ia, ib, ic, wb, wc)) begin
                corner_a = heights[ia];
                corner_b = heights[ib];
                corner_c = heights[ic];
                acc = corner_a * ONE_FIX + (corner_b - corner_a) * wb
                    + (corner_c - corner_a) * wc;
                if (acc < 0) acc = 0;
                h = (acc * longint'(scale) + (255 * ONE_FIX) / 2) / (255 * ONE_FIX);
                if (h > 65535) h = 65535;
                r.height = h[HEIGHT_W-1:0];
                r.in_range = 1'b1;
            end
            expected_heights.insert(expected_heights.size(), r);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t: %s", $time, what);
        endtask

        task check_result(logic [HEIGHT_W-1:0] height, logic in_range);
            height_result_t e;
            if (expected_heights.size() == 0) begin
                report_mismatch($sformatf("unexpected result: height %0d in_range %b",
                                          height, in_range));
                return;
            end
            e = expected_heights.pop_front();
            if (height !== e.height)
                report_mismatch($sformatf("height %0d, expected %0d", height, e.height));
            if (in_range !== e.in_range)
                report_mismatch($sformatf("in_range %b, expected %b", in_range, e.in_range));
        endtask
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_opcode;
    logic [15:0]                s_sample_index;
    logic [SAMPLE_W-1:0]        s_sample_value;
    logic signed [QPOS_W-1:0]   s_query_x;
    logic signed [QPOS_W-1:0]   s_query_z;
    logic                       m_valid;
    logic                       m_ready;
    logic [HEIGHT_W-1:0]        m_height_out;
    logic                       m_in_range;

    bit                         no_gaps = 1'b0;
    height_scoreboard           scoreboard = new();

    heightfield_triangle_sampler_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_sample_index (s_sample_index),
        .s_sample_value (s_sample_value),
        .s_query_x      (s_query_x),
        .s_query_z      (s_query_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_height_out   (m_height_out),
        .m_in_range     (m_in_range)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_beat(input logic op, input logic [15:0] index,
                             input logic [SAMPLE_W-1:0] value,
                             input logic signed [QPOS_W-1:0] qx, qz);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode = op;
        s_sample_index = index;
        s_sample_value = value;
        s_query_x = qx;
        s_query_z = qz;
        s_valid = 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        scoreboard.note_beat(op, index, value, qx, qz);
    endtask

    task automatic write_sample(input logic [15:0] index, input logic [SAMPLE_W-1:0] value);
        send_beat(OP_WRITE, index, value, QPOS_W'($urandom), QPOS_W'($urandom));
    endtask

    task automatic query_at(input logic signed [QPOS_W-1:0] qx, qz);
        send_beat(OP_QUERY, 16'($urandom), SAMPLE_W'($urandom), qx, qz);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (scoreboard.expected_heights.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int unsigned data);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = data[CFG_W-1:0];
        @(negedge aclk);
        cfg_we = 1'b0;
        scoreboard.set_register(index, cfg_data);
    endtask

    task automatic configure(input int unsigned cols, rws, gain);
        settle();
        write_register(REG_GRID_COLUMNS, cols);
        write_register(REG_GRID_ROWS, rws);
        write_register(REG_HEIGHT_SCALE, gain);
    endtask

    task automatic fill_cell(input int cx, cz);
        int cols;
        cols = scoreboard.usable(scoreboard.columns);
        write_sample(16'(cx + cz * cols), pick_sample());
        write_sample(16'(cx + 1 + cz * cols), pick_sample());
        write_sample(16'(cx + (cz + 1) * cols), pick_sample());
        write_sample(16'(cx + 1 + (cz + 1) * cols), pick_sample());
    endtask

    task automatic query_in_cell(input int cx, cz);
        int fx, fz;
        fx = $urandom_range(0, ONE_FIX - 1);
        fz = $urandom_range(0, ONE_FIX - 1);
        case ($urandom_range(0, 5))
            0: fz = fx;
            1: fz = 0;
            2: fx = ONE_FIX - 1;
            default: ;
        endcase
        query_at(QPOS_W'(cx * ONE_FIX + fx), QPOS_W'(cz * ONE_FIX + fz));
    endtask

    task automatic stray_query();
        logic signed [QPOS_W-1:0] qx, qz;
        int span_x, span_z;
        span_x = (scoreboard.usable(scoreboard.columns) + 1) * ONE_FIX;
        span_z = (scoreboard.usable(scoreboard.rows) + 1) * ONE_FIX;
        for (int tries = 0; tries < 8; tries++) begin
            if ($urandom_range(0, 1)) begin
                qx = QPOS_W'($urandom);
                qz = QPOS_W'($urandom);
            end else begin
                qx = QPOS_W'($urandom_range(0, span_x - 1));
                qz = QPOS_W'($urandom_range(0, span_z - 1));
            end
            if (scoreboard.readable(qx, qz)) break;
        end
        // A negative column keeps the query off samples that were never written.
        if (!scoreboard.readable(qx, qz)) qx[QPOS_W-1] = 1'b1;
        query_at(qx, qz);
    endtask

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            m_ready = (stall == 0);
            if (stall > 0) begin
                @(posedge aclk);
                while (m_valid !== 1'b1) @(posedge aclk);
                repeat (stall) @(negedge aclk);
                m_ready = 1'b1;
            end
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            scoreboard.check_result(m_height_out, m_in_range);
        end
    end

    initial begin
        int cx, cz, cols, rws, sent, pick;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_opcode = OP_WRITE;
        s_sample_index = '0;
        s_sample_value = '0;
        s_query_x = '0;
        s_query_z = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_sample(16'd0, 8'd10);
        write_sample(16'd1, 8'd255);
        write_sample(16'd256, 8'd0);
        write_sample(16'd257, 8'd128);
        query_at(17'h00000, 17'h00000);
        query_at(17'h00080, 17'h00040);
        query_at(17'h00040, 17'h00080);
        query_at(17'h0007F, 17'h0007F);
        query_at(17'h000FF, 17'h000FF);
        query_at(17'h000FF, 17'h00000);
        write_sample(16'd65278, 8'd255);
        write_sample(16'd65279, 8'd0);
        write_sample(16'd65534, 8'd255);
        write_sample(16'd65535, 8'd255);
        query_at(17'h0FEFF, 17'h0FEFF);
        query_at(17'h0FE80, 17'h0FEC0);
        query_at(17'h0FF00, 17'h00000);
        query_at(17'h0FFFF, 17'h0FFFF);
        query_at(17'h1FFFF, 17'h00000);
        query_at(17'h00000, 17'h10000);
        configure(256, 256, 65535);
        query_at(17'h0FEFF, 17'h0FEFF);
        query_at(17'h00080, 17'h00040);
        configure(256, 256, 0);
        query_at(17'h0FEFF, 17'h0FEFF);

        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: configure(256, 256, 256);
                1: configure(2, 2, $urandom_range(0, 65535));
                2: configure(257, 511, 65535);
                3: configure(0, 256, 1000);
                4: configure(256, 1, 256);
                5: configure($urandom_range(2, 20), $urandom_range(2, 20),
                             $urandom_range(0, 65535));
                6: configure(3, 256, 0);
                7: configure(511, 2, $urandom_range(0, 65535));
                8: configure($urandom_range(2, 511), $urandom_range(2, 511),
                             $urandom_range(0, 65535));
                default: configure(256, 256, 65535);
            endcase
            no_gaps = (phase % 3 == 2);
            sent = 0;
            while (sent < 80) begin
                cols = scoreboard.usable(scoreboard.columns);
                rws = scoreboard.usable(scoreboard.rows);
                pick = $urandom_range(0, 9);
                if (pick < 6 && cols >= 2 && rws >= 2) begin
                    cx = $urandom_range(0, cols - 2);
                    cz = $urandom_range(0, rws - 2);
                    fill_cell(cx, cz);
                    sent += 4;
                    repeat ($urandom_range(1, 3)) begin
                        query_in_cell(cx, cz);
                        sent++;
                    end
                end else if (pick == 8) begin
                    write_sample(16'($urandom), pick_sample());
                    sent++;
                end else if (pick == 9 && $urandom_range(0, 7) == 0) begin
                    settle();
                end else begin
                    stray_query();
                    sent++;
                end
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        for (int n = 0; n < 5000 && scoreboard.expected_heights.size() != 0; n++)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (scoreboard.expected_heights.size() != 0)
            scoreboard.report_mismatch($sformatf("%0d results never arrived",
                                                 scoreboard.expected_heights.size()));
        if (scoreboard.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
